// ===== rtl/malu_pkg.sv =====
// ----------------------------------------------------------------------------
// malu_pkg
// Shared types and codes for the MIPS-style ALU with control.
// ----------------------------------------------------------------------------
package malu_pkg;

    localparam int unsigned DataW  = 32;
    localparam int unsigned FunctW = 6;
    localparam int unsigned OpW    = 3;

    localparam logic [OpW-1:0] OP_ADD   = 3'd0;
    localparam logic [OpW-1:0] OP_SUB   = 3'd1;
    localparam logic [OpW-1:0] OP_NONE  = 3'd2;
    localparam logic [OpW-1:0] OP_AND   = 3'd3;
    localparam logic [OpW-1:0] OP_OR    = 3'd4;
    localparam logic [OpW-1:0] OP_SLT   = 3'd5;
    localparam logic [OpW-1:0] OP_SHL16 = 3'd6;
    localparam logic [OpW-1:0] OP_FUNCT = 3'd7;

    localparam logic [FunctW-1:0] FN_ADD   = 6'h20;
    localparam logic [FunctW-1:0] FN_SUB   = 6'h22;
    localparam logic [FunctW-1:0] FN_SLT   = 6'h2a;
    localparam logic [FunctW-1:0] FN_SLTU  = 6'h2b;
    localparam logic [FunctW-1:0] FN_AND   = 6'h24;
    localparam logic [FunctW-1:0] FN_OR    = 6'h25;
    localparam logic [FunctW-1:0] FN_SHL16 = 6'h06;

    localparam int unsigned ShiftAmt = 16;

    typedef enum logic [2:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_SLT,
        ALU_SLTU,
        ALU_AND,
        ALU_OR,
        ALU_SHL16,
        ALU_NONE
    } alu_sel_t;

    typedef struct packed {
        alu_sel_t sel;
        logic     bad;
    } alu_ctrl_t;

endpackage

// ===== rtl/malu_ctrl.sv =====
// ----------------------------------------------------------------------------
// malu_ctrl
// ALU control decode: op class and funct field to an ALU operation select.
// ----------------------------------------------------------------------------
module malu_ctrl (
    input  logic [malu_pkg::OpW-1:0]    op_class,
    input  logic [malu_pkg::FunctW-1:0] func_code,
    output malu_pkg::alu_ctrl_t         ctrl
);
    import malu_pkg::*;

    alu_sel_t funct_sel;
    alu_sel_t sel;

    always_comb begin
        unique case (func_code)
            FN_ADD:   funct_sel = ALU_ADD;
            FN_SUB:   funct_sel = ALU_SUB;
            FN_SLT:   funct_sel = ALU_SLT;
            FN_SLTU:  funct_sel = ALU_SLTU;
            FN_AND:   funct_sel = ALU_AND;
            FN_OR:    funct_sel = ALU_OR;
            FN_SHL16: funct_sel = ALU_SHL16;
            default:  funct_sel = ALU_NONE;
        endcase
    end

    always_comb begin
        unique case (op_class)
            OP_ADD:   sel = ALU_ADD;
            OP_SUB:   sel = ALU_SUB;
            OP_NONE:  sel = ALU_NONE;
            OP_AND:   sel = ALU_AND;
            OP_OR:    sel = ALU_OR;
            OP_SLT:   sel = ALU_SLT;
            OP_SHL16: sel = ALU_SHL16;
            OP_FUNCT: sel = funct_sel;
            default:  sel = ALU_NONE;
        endcase
    end

    assign ctrl.sel = sel;
    assign ctrl.bad = (sel == ALU_NONE);

endmodule

// ===== rtl/malu_core.sv =====
// ----------------------------------------------------------------------------
// malu_core
// 32-bit ALU datapath: add, sub, slt, sltu, and, or, shift-left-by-16.
// ----------------------------------------------------------------------------
module malu_core (
    input  logic [malu_pkg::DataW-1:0] op_a,
    input  logic [malu_pkg::DataW-1:0] op_b,
    input  malu_pkg::alu_sel_t         sel,
    output logic [malu_pkg::DataW-1:0] result
);
    import malu_pkg::*;

    always_comb begin
        unique case (sel)
            ALU_ADD:   result = op_a + op_b;
            ALU_SUB:   result = op_a - op_b;
            ALU_SLT:   result = DataW'($signed(op_a) < $signed(op_b));
            ALU_SLTU:  result = DataW'(op_a < op_b);
            ALU_AND:   result = op_a & op_b;
            ALU_OR:    result = op_a | op_b;
            ALU_SHL16: result = op_b << ShiftAmt;
            default:   result = '0;
        endcase
    end

endmodule

// ===== rtl/mips_alu_with_control.sv =====
// ----------------------------------------------------------------------------
// mips_alu_with_control
// MIPS-style ALU with ALU-control decode, input and result registers.
//
//   channel | direction | handshake         | payload
//   s_      | in        | s_valid / s_ready | reg_a reg_b imm_ext func_code
//           |           |                   | op_class use_imm
//   m_      | out       | m_valid / m_ready | alu_out is_zero unsupported
//
// One item per cycle sustained while m_ready is high; an input transfer passes
// through the input register, then the result register, before the result is valid.
// Reset clears both stage valid bits; payload registers are not reset.
// A stalled result holds; the input stage still advances into a free result
// register, and s_ready drops only when both stages are full and m_ready is low.
// ----------------------------------------------------------------------------
module mips_alu_with_control (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [malu_pkg::DataW-1:0]  s_reg_a,
    input  logic [malu_pkg::DataW-1:0]  s_reg_b,
    input  logic [malu_pkg::DataW-1:0]  s_imm_ext,
    input  logic [malu_pkg::FunctW-1:0] s_func_code,
    input  logic [malu_pkg::OpW-1:0]    s_op_class,
    input  logic                        s_use_imm,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [malu_pkg::DataW-1:0]  m_alu_out,
    output logic                        m_is_zero,
    output logic                        m_unsupported
);
    import malu_pkg::*;

    logic              in_valid_reg;
    logic [DataW-1:0]  reg_a_reg;
    logic [DataW-1:0]  op_b_reg;
    logic [FunctW-1:0] func_code_reg;
    logic [OpW-1:0]    op_class_reg;

    logic              out_valid_reg;
    logic [DataW-1:0]  alu_out_reg;
    logic              unsupported_reg;

    logic              out_free;
    logic              in_free;
    alu_ctrl_t         ctrl;
    logic [DataW-1:0]  core_result;
    logic [DataW-1:0]  alu_out_next;

    assign out_free = !out_valid_reg || m_ready;
    assign in_free  = !in_valid_reg || out_free;
    assign s_ready  = in_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_free) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_free && s_valid) begin
            reg_a_reg     <= s_reg_a;
            op_b_reg      <= s_use_imm ? s_imm_ext : s_reg_b;
            func_code_reg <= s_func_code;
            op_class_reg  <= s_op_class;
        end
    end

    malu_ctrl u_ctrl (
        .op_class  (op_class_reg),
        .func_code (func_code_reg),
        .ctrl      (ctrl)
    );

    malu_core u_core (
        .op_a   (reg_a_reg),
        .op_b   (op_b_reg),
        .sel    (ctrl.sel),
        .result (core_result)
    );

    assign alu_out_next = ctrl.bad ? '0 : core_result;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && in_valid_reg) begin
            alu_out_reg     <= alu_out_next;
            unsupported_reg <= ctrl.bad;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_alu_out     = alu_out_reg;
    assign m_is_zero     = (alu_out_reg == '0);
    assign m_unsupported = unsupported_reg;

endmodule

// ===== rtl/malu_checker.sv =====
// ----------------------------------------------------------------------------
// malu_checker
// Port-level assertions for mips_alu_with_control, bound to the top level.
// ----------------------------------------------------------------------------
module malu_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [malu_pkg::DataW-1:0]  m_alu_out,
    input logic                        m_is_zero,
    input logic                        m_unsupported
);
    import malu_pkg::*;

    // result held while stalled
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_alu_out)
            && $stable(m_unsupported))
        else $error("result changed while stalled");

    a_zero_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_is_zero == (m_alu_out == '0)))
        else $error("zero flag disagrees with result");

    a_unsup_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_unsupported |-> (m_alu_out == '0))
        else $error("unsupported op gave nonzero result");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // an input transfer while no result is valid shows a result once it has passed the input and result registers
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !m_valid |=> ##1 m_valid)
        else $error("result missing after input transfer");

endmodule

bind mips_alu_with_control malu_checker u_malu_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_alu_out     (m_alu_out),
    .m_is_zero     (m_is_zero),
    .m_unsupported (m_unsupported)
);
